// ===== design/lprm_pkg.sv =====
// Shared types and constants for the longest-prefix route matcher.
`timescale 1ns / 1ps
`default_nettype none

package lprm_pkg;

    localparam int DEF_NUM_ROUTES = 16;
    localparam int DEF_PREFIX_MAX = 32;

    localparam int FUNC_W   = 2;
    localparam int RIDX_W   = 4;
    localparam int CPOS_W   = 5;
    localparam int CHAR_W   = 8;
    localparam int PLEN_W   = 5;
    localparam int PORT_W   = 16;
    localparam int CFG_W    = 5;
    localparam int STATUS_W = 2;

    // Wide enough for any index, length or count across the parameter range.
    localparam int WIDE_W = 7;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [CHAR_W-1:0] SLASH_CHAR = 8'h2F;

    localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ROUTE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PATH   = 2'd2;

    typedef enum logic [1:0] {
        OP_PREFIX,
        OP_ROUTE,
        OP_PATH
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_MATCH     = 2'd0,
        STAT_NO_MATCH  = 2'd1,
        STAT_NO_SLASH  = 2'd2,
        STAT_NO_ROUTES = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_SCAN,
        ST_RESULT
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [RIDX_W-1:0]  ridx;
        logic [CPOS_W-1:0]  cpos;
        logic [CHAR_W-1:0]  chr;
        logic [PLEN_W-1:0]  plen;
        logic [PORT_W-1:0]  port;
        logic               last;
    } q_entry_t;

endpackage

`default_nettype wire

// ===== design/lprm_front.sv =====
// Front end: classifies input transactions and queues the in-range ones for the back end.
`timescale 1ns / 1ps
`default_nettype none

module lprm_front #(
    parameter int NUM_ROUTES = lprm_pkg::DEF_NUM_ROUTES,
    parameter int PREFIX_MAX = lprm_pkg::DEF_PREFIX_MAX
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [lprm_pkg::FUNC_W-1:0] func,
    input  wire logic [lprm_pkg::RIDX_W-1:0] route_index,
    input  wire logic [lprm_pkg::CPOS_W-1:0] char_pos,
    input  wire logic [lprm_pkg::CHAR_W-1:0] char_value,
    input  wire logic [lprm_pkg::PLEN_W-1:0] prefix_length,
    input  wire logic [lprm_pkg::PORT_W-1:0] port_value,
    input  wire logic                        last,
    output logic                             q_valid,
    output lprm_pkg::q_entry_t               q_data,
    input  wire logic                        q_pop
);
    import lprm_pkg::*;

    q_entry_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                keep;
    logic                push;
    logic                ridx_ok;
    logic                cpos_ok;
    op_t                 op;
    q_entry_t            entry_in;

    assign ridx_ok = WIDE_W'(route_index) < WIDE_W'(NUM_ROUTES);
    assign cpos_ok = WIDE_W'(char_pos) < WIDE_W'(PREFIX_MAX);

    always_comb
    begin
        keep = 1'b0;
        op   = OP_PREFIX;
        unique case (func)
            FUNC_PREFIX:
            begin
                op   = OP_PREFIX;
                keep = ridx_ok && cpos_ok;
            end
            FUNC_ROUTE:
            begin
                op   = OP_ROUTE;
                keep = ridx_ok;
            end
            FUNC_PATH:
            begin
                op   = OP_PATH;
                keep = 1'b1;
            end
            default:
            begin
                op   = OP_PREFIX;
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        entry_in.op   = op;
        entry_in.ridx = route_index;
        entry_in.cpos = char_pos;
        entry_in.chr  = char_value;
        entry_in.plen = prefix_length;
        entry_in.port = port_value;
        entry_in.last = last;
    end

    assign in_ready = count_reg != QCNT_W'(QDEPTH);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = count_reg != '0;
    assign q_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

`default_nettype wire

// ===== design/lprm_back.sv =====
// Back end: route table, parallel byte compare, longest-match scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module lprm_back #(
    parameter int NUM_ROUTES = lprm_pkg::DEF_NUM_ROUTES,
    parameter int PREFIX_MAX = lprm_pkg::DEF_PREFIX_MAX
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lprm_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          q_valid,
    input  wire lprm_pkg::q_entry_t            q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lprm_pkg::STATUS_W-1:0]      status,
    output logic [lprm_pkg::RIDX_W-1:0]        best_route,
    output logic [lprm_pkg::PLEN_W-1:0]        match_length,
    output logic [lprm_pkg::PORT_W-1:0]        backend_port
);
    import lprm_pkg::*;

    localparam int RW = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
    localparam int AW = $clog2(PREFIX_MAX);
    localparam int LW = $clog2(PREFIX_MAX + 1);
    localparam int DW = NUM_ROUTES * CHAR_W;

    back_state_t            state_reg;
    back_state_t            state_next;

    logic [CFG_W-1:0]       routes_reg;
    logic [LW-1:0]          len_reg [NUM_ROUTES];
    logic [PORT_W-1:0]      port_reg [NUM_ROUTES];
    logic [DW-1:0]          prefix_mem [PREFIX_MAX];
    logic [DW-1:0]          row_reg;

    logic                   cmp_valid_reg;
    logic                   cmp_valid_next;
    logic [CHAR_W-1:0]      cmp_char_reg;
    logic [LW-1:0]          cmp_pos_reg;
    logic [NUM_ROUTES-1:0]  match_reg;
    logic [NUM_ROUTES-1:0]  match_next;
    logic [LW-1:0]          pos_reg;
    logic [LW-1:0]          pos_next;
    logic                   slash_reg;
    logic                   slash_next;

    logic [RW-1:0]          scan_reg;
    logic [RW-1:0]          scan_next;
    logic [RW-1:0]          best_idx_reg;
    logic [RW-1:0]          best_idx_next;
    logic [LW-1:0]          best_len_reg;
    logic [LW-1:0]          best_len_next;
    logic [PORT_W-1:0]      best_port_reg;
    logic [PORT_W-1:0]      best_port_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [RIDX_W-1:0]      best_route_reg;
    logic [PLEN_W-1:0]      match_length_reg;
    logic [PORT_W-1:0]      backend_port_reg;
    status_t                res_status;

    logic                   wr_prefix;
    logic                   wr_route;
    logic                   path_go;
    logic                   scan_init;
    logic                   scan_step;
    logic                   res_load;
    logic                   path_pos_ok;
    logic                   scan_last;
    logic                   cand;
    logic [WIDE_W-1:0]      active_w;
    logic [WIDE_W-1:0]      plen_w;
    logic [WIDE_W-1:0]      len_sat_w;
    logic [RW-1:0]          q_ridx;
    logic [AW-1:0]          q_row;
    logic [AW-1:0]          path_row;

    assign q_ridx   = WIDE_W'(q_data.ridx) >> 0 == '0 ? '0 : RW'(WIDE_W'(q_data.ridx));
    assign q_row    = AW'(WIDE_W'(q_data.cpos));
    assign path_row = AW'(WIDE_W'(pos_reg));

    assign active_w = (WIDE_W'(routes_reg) > WIDE_W'(NUM_ROUTES)) ?
                      WIDE_W'(NUM_ROUTES) : WIDE_W'(routes_reg);
    assign plen_w    = WIDE_W'(q_data.plen);
    assign len_sat_w = (plen_w > WIDE_W'(PREFIX_MAX)) ? WIDE_W'(PREFIX_MAX) : plen_w;

    assign path_pos_ok = WIDE_W'(pos_reg) < WIDE_W'(PREFIX_MAX);
    assign scan_last   = WIDE_W'(scan_reg) == (active_w - WIDE_W'(1));

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        wr_prefix  = 1'b0;
        wr_route   = 1'b0;
        path_go    = 1'b0;
        scan_init  = 1'b0;
        scan_step  = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_data.op)
                        OP_PREFIX: wr_prefix = 1'b1;
                        OP_ROUTE:  wr_route  = 1'b1;
                        OP_PATH:
                        begin
                            path_go = 1'b1;
                            if (q_data.last)
                            begin
                                state_next = ST_WAIT;
                            end
                        end
                        default:   wr_prefix = 1'b0;
                    endcase
                end
            end
            ST_WAIT:
            begin
                scan_init = 1'b1;
                if (active_w == '0 || !slash_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        match_next = match_reg;
        if (cmp_valid_reg)
        begin
            for (int i = 0; i < NUM_ROUTES; i++)
            begin
                if (cmp_pos_reg < len_reg[i] && row_reg[i*CHAR_W +: CHAR_W] != cmp_char_reg)
                begin
                    match_next[i] = 1'b0;
                end
            end
        end
        if (res_load)
        begin
            match_next = '1;
        end
    end

    always_comb
    begin
        cmp_valid_next = path_go && path_pos_ok;
        pos_next       = pos_reg;
        slash_next     = slash_reg;
        if (path_go && path_pos_ok)
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (path_go && pos_reg == '0)
        begin
            slash_next = q_data.chr == SLASH_CHAR;
        end
        if (res_load)
        begin
            pos_next   = '0;
            slash_next = 1'b0;
        end
    end

    assign cand = match_reg[scan_reg] && len_reg[scan_reg] <= pos_reg &&
                  len_reg[scan_reg] > best_len_reg;

    always_comb
    begin
        scan_next      = scan_reg;
        best_idx_next  = best_idx_reg;
        best_len_next  = best_len_reg;
        best_port_next = best_port_reg;
        if (scan_init)
        begin
            scan_next      = '0;
            best_idx_next  = '0;
            best_len_next  = '0;
            best_port_next = '0;
        end
        else if (scan_step)
        begin
            scan_next = scan_reg + 1'b1;
            if (cand)
            begin
                best_idx_next  = scan_reg;
                best_len_next  = len_reg[scan_reg];
                best_port_next = port_reg[scan_reg];
            end
        end
    end

    always_comb
    begin
        if (active_w == '0)
        begin
            res_status = STAT_NO_ROUTES;
        end
        else if (!slash_reg)
        begin
            res_status = STAT_NO_SLASH;
        end
        else if (best_len_reg != '0)
        begin
            res_status = STAT_MATCH;
        end
        else
        begin
            res_status = STAT_NO_MATCH;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            routes_reg    <= '0;
            match_reg     <= '1;
            pos_reg       <= '0;
            slash_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ROUTES; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            match_reg     <= match_next;
            pos_reg       <= pos_next;
            slash_reg     <= slash_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                routes_reg <= cfg_wdata;
            end
            if (wr_route)
            begin
                len_reg[q_ridx] <= LW'(len_sat_w);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_route)
        begin
            port_reg[q_ridx] <= q_data.port;
        end
        if (path_go)
        begin
            cmp_char_reg <= q_data.chr;
            cmp_pos_reg  <= pos_reg;
        end
        scan_reg      <= scan_next;
        best_idx_reg  <= best_idx_next;
        best_len_reg  <= best_len_next;
        best_port_reg <= best_port_next;
        if (res_load)
        begin
            status_reg <= res_status;
            if (res_status == STAT_MATCH)
            begin
                best_route_reg   <= RIDX_W'(WIDE_W'(best_idx_reg));
                match_length_reg <= PLEN_W'(WIDE_W'(best_len_reg));
                backend_port_reg <= best_port_reg;
            end
            else
            begin
                best_route_reg   <= '0;
                match_length_reg <= '0;
                backend_port_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_prefix)
        begin
            prefix_mem[q_row][q_ridx*CHAR_W +: CHAR_W] <= q_data.chr;
        end
        if (path_go && path_pos_ok)
        begin
            row_reg <= prefix_mem[path_row];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign best_route   = best_route_reg;
    assign match_length = match_length_reg;
    assign backend_port = backend_port_reg;

endmodule

`default_nettype wire

// ===== design/longest_prefix_route_match.sv =====
// Top level of the longest-prefix route matcher.
//
// Input transactions carry a func code: prefix byte writes and route length/port
// writes load the table, and path bytes stream a request path, the final one marked
// by last. Only a path byte marked last produces an output transaction, which reports
// the status, the chosen route, its prefix length and its backend port.
// The cfg_we/cfg_wdata port sets how many routes take part; write it only while idle.
// Table loads and path bytes that are not last are taken one per cycle while the queue
// is not full. A final path byte holds the back end while it reads the prefix memory
// row into a register, compares that row with the byte, scans the routes in use one by
// one (the route count capped at NUM_ROUTES; none when no routes take part or the path
// lacks a leading slash), and loads the output register.
// A two-entry queue sits between the front end and the back end, so input transactions
// are still taken while the back end scans or waits on a stalled receiver.
// When out_ready is low, the result is held in the output register; the next result
// then waits in the back end, and in_ready drops once the queue is full. Reset empties
// the queue, clears the route lengths, the route count and out_valid, and readies
// the path state for a new request.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_route_match #(
    parameter int NUM_ROUTES = lprm_pkg::DEF_NUM_ROUTES,
    parameter int PREFIX_MAX = lprm_pkg::DEF_PREFIX_MAX
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lprm_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lprm_pkg::FUNC_W-1:0]   func,
    input  wire logic [lprm_pkg::RIDX_W-1:0]   route_index,
    input  wire logic [lprm_pkg::CPOS_W-1:0]   char_pos,
    input  wire logic [lprm_pkg::CHAR_W-1:0]   char_value,
    input  wire logic [lprm_pkg::PLEN_W-1:0]   prefix_length,
    input  wire logic [lprm_pkg::PORT_W-1:0]   port_value,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lprm_pkg::STATUS_W-1:0]      status,
    output logic [lprm_pkg::RIDX_W-1:0]        best_route,
    output logic [lprm_pkg::PLEN_W-1:0]        match_length,
    output logic [lprm_pkg::PORT_W-1:0]        backend_port
);
    import lprm_pkg::*;

    logic      q_valid;
    logic      q_pop;
    q_entry_t  q_data;

    lprm_front #(
        .NUM_ROUTES (NUM_ROUTES),
        .PREFIX_MAX (PREFIX_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .route_index   (route_index),
        .char_pos      (char_pos),
        .char_value    (char_value),
        .prefix_length (prefix_length),
        .port_value    (port_value),
        .last          (last),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop)
    );

    lprm_back #(
        .NUM_ROUTES (NUM_ROUTES),
        .PREFIX_MAX (PREFIX_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .best_route   (best_route),
        .match_length (match_length),
        .backend_port (backend_port)
    );

endmodule

`default_nettype wire

// ===== design/lprm_checker.sv =====
// Port-level checker for the route matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lprm_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [lprm_pkg::STATUS_W-1:0] status,
    input wire logic [lprm_pkg::RIDX_W-1:0]   best_route,
    input wire logic [lprm_pkg::PLEN_W-1:0]   match_length,
    input wire logic [lprm_pkg::PORT_W-1:0]   backend_port
);
    import lprm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(best_route) && $stable(match_length) && $stable(backend_port))
        else $error("Stalled output transaction changed.");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_MATCH |->
        best_route == '0 && match_length == '0 && backend_port == '0)
        else $error("Result without a match carries nonzero fields.");

    a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_MATCH |-> match_length != '0)
        else $error("Match reported with an empty prefix.");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid && in_ready)
        else $error("Outputs not idle during reset.");

endmodule

bind longest_prefix_route_match lprm_checker u_lprm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .best_route   (best_route),
    .match_length (match_length),
    .backend_port (backend_port)
);

`default_nettype wire
